### rtl/core/assert_macros.svh
// assertion macros shared by the rtl, clocked on clk with active-low reset rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true on a rising clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/uifc_pkg.sv
// shared types and constants of the uart idle frame classifier
`timescale 1ns / 1ps

package uifc_pkg;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int LEN_W    = 11;
    localparam int TYPE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [LIMIT_W-1:0]    limit_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [TYPE_W-1:0]     ftype_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // frame types
    localparam ftype_t TYPE_INVALID = 2'd0;
    localparam ftype_t TYPE_SUM     = 2'd1;
    localparam ftype_t TYPE_AT      = 2'd2;

    // register indexes
    localparam cfg_idx_t REG_HEAD_BYTE  = 2'd0;
    localparam cfg_idx_t REG_IDLE_LIMIT = 2'd1;

    // register reset values
    localparam byte_t  HEAD_BYTE_RST  = 8'd72;
    localparam limit_t IDLE_LIMIT_RST = 16'd20;

    // character codes of AT frames
    localparam byte_t CHR_A  = 8'h41;
    localparam byte_t CHR_PLUS = 8'h2B;
    localparam byte_t CHR_CR = 8'h0D;
    localparam byte_t CHR_LF = 8'h0A;

    // shortest frame that can be classified
    localparam int MIN_FRAME = 2;

endpackage

### rtl/core/uifc_if.sv
// valid/ready channel interfaces: input items, results and register writes
`timescale 1ns / 1ps

interface uifc_item_if;
    import uifc_pkg::*;
    logic  valid;
    logic  ready;
    logic  kind;
    byte_t rx_byte;
    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface uifc_result_if;
    import uifc_pkg::*;
    logic   valid;
    logic   ready;
    ftype_t frame_type;
    len_t   frame_length;
    modport source (output valid, output frame_type, output frame_length, input ready);
    modport sink   (input valid, input frame_type, input frame_length, output ready);
endinterface

interface uifc_cfg_if;
    import uifc_pkg::*;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/uart_idle_frame_classifier_unit.sv
// top level of the uart idle frame classifier
`timescale 1ns / 1ps

// Takes one transaction per cycle on item: a received byte (kind 0) or one time
// tick (kind 1). Bytes are not stored; the block keeps the byte count, the 8-bit
// running sum, the first byte and the last two bytes. Each byte restarts the idle
// timer, even a byte dropped because the frame already holds MAX_FRAME bytes.
// When idle_limit ticks pass with no byte (0 acts as 1) the frame ends and one
// result transaction gives its type (0 invalid, 1 checksum, 2 AT) and length,
// then the frame state clears and the timer stops until the next byte. Ticks
// while the timer is stopped do nothing. Each item's state update is done at
// the accepting edge, and a result lands in the output register the same
// edge, so throughput is one item per cycle while item.ready is high.
// item.ready drops only while the output register holds a result that
// the sink is not taking. Register writes on cfg are always taken at once
// (index 0 head_byte, 1 idle_limit, other indexes ignored) and should only be
// made while the block is idle.
module uart_idle_frame_classifier_unit #(
    parameter int MAX_FRAME = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    uifc_item_if.sink     item,
    uifc_result_if.source result,
    uifc_cfg_if.sink      cfg
);
    import uifc_pkg::*;

    // count must hold MAX_FRAME itself
    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);

    // configuration registers
    byte_t  head_reg;
    limit_t limit_reg;

    // frame state
    logic [CNT_W-1:0] count_reg, count_next;
    byte_t            sum_reg, sum_next;
    byte_t            first_reg, first_next;
    byte_t            last_reg, last_next;
    byte_t            prev_reg, prev_next;
    limit_t           idle_reg, idle_next;
    logic             armed_reg, armed_next;

    // output register
    logic   out_valid_reg, out_valid_next;
    ftype_t type_reg, type_next;
    len_t   len_reg, len_next;

    logic             in_fire;
    logic             res_load;
    logic             is_byte;
    logic             is_tick;
    limit_t           limit_eff;
    limit_t           ticks_inc;
    logic             expire;
    byte_t            sum_but_last;
    ftype_t           frame_class;
    logic [EXT_W-1:0] len_ext;

    // register writes never stall
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= HEAD_BYTE_RST;
            limit_reg <= IDLE_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEAD_BYTE:  head_reg  <= cfg.data[BYTE_W-1:0];
                REG_IDLE_LIMIT: limit_reg <= cfg.data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // accept while the output register is empty or being drained
    assign item.ready = !out_valid_reg || result.ready;
    assign in_fire    = item.valid && item.ready;
    assign is_byte    = in_fire && (item.kind == KIND_BYTE);
    assign is_tick    = in_fire && (item.kind == KIND_TICK) && armed_reg;

    // idle timer: a zero limit behaves as one
    assign limit_eff = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;
    assign ticks_inc = idle_reg + LIMIT_W'(1);
    assign expire    = ticks_inc >= limit_eff;
    assign res_load  = is_tick && expire;

    // classification of the frame held in the state registers
    assign sum_but_last = sum_reg - last_reg;

    always_comb
    begin
        frame_class = TYPE_INVALID;
        if (count_reg >= CNT_MIN)
        begin
            if (first_reg == head_reg)
            begin
                frame_class = (sum_but_last == last_reg) ? TYPE_SUM : TYPE_INVALID;
            end
            else if ((first_reg == CHR_A || first_reg == CHR_PLUS) &&
                     prev_reg == CHR_CR && last_reg == CHR_LF)
            begin
                frame_class = TYPE_AT;
            end
        end
    end

    // length is the count taken to 11 bits
    assign len_ext = EXT_W'(count_reg);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        last_next  = last_reg;
        prev_next  = prev_reg;
        idle_next  = idle_reg;
        armed_next = armed_reg;

        if (is_byte)
        begin
            // full frame drops the byte but still restarts the timer
            if (count_reg < CNT_MAX)
            begin
                if (count_reg == '0)
                begin
                    first_next = item.rx_byte;
                end
                prev_next  = last_reg;
                last_next  = item.rx_byte;
                sum_next   = sum_reg + item.rx_byte;
                count_next = count_reg + CNT_W'(1);
            end
            idle_next  = '0;
            armed_next = 1'b1;
        end
        else if (is_tick)
        begin
            if (expire)
            begin
                count_next = '0;
                sum_next   = '0;
                first_next = '0;
                last_next  = '0;
                prev_next  = '0;
                idle_next  = '0;
                armed_next = 1'b0;
            end
            else
            begin
                idle_next = ticks_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            prev_reg  <= '0;
            idle_reg  <= '0;
            armed_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            prev_reg  <= prev_next;
            idle_reg  <= idle_next;
            armed_reg <= armed_next;
        end
    end

    // output register, loaded when a frame ends
    always_comb
    begin
        out_valid_next = out_valid_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            type_next      = frame_class;
            len_next       = len_ext[LEN_W-1:0];
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        len_reg  <= len_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_type   = type_reg;
    assign result.frame_length = len_reg;

`include "assert_macros.svh"

    `ASSERT_NEVER(a_count_bound, count_reg > CNT_MAX, "byte count above frame limit")
    `ASSERT_CLK(a_stopped_timer_clear, !armed_reg |-> idle_reg == '0,
        "idle ticks held while timer stopped")
    `ASSERT_CLK(a_end_clears_frame, res_load |=> count_reg == '0 && !armed_reg && out_valid_reg,
        "frame end did not clear state or post a result")
    `ASSERT_CLK(a_empty_frame_clear, count_reg == '0 |-> sum_reg == '0 && first_reg == '0,
        "empty frame holds stale data")
    `ASSERT_NEVER(a_no_overwrite, res_load && out_valid_reg && !result.ready,
        "pending result overwritten")

endmodule
